// ----- rtl/fractal_quadratic_vector_step_core_assert.svh -----
// Assertion macros used by the fractal step core pipeline control.
`ifndef FRACTAL_QUADRATIC_VECTOR_STEP_CORE_ASSERT_SVH
`define FRACTAL_QUADRATIC_VECTOR_STEP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FQVS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqvs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FQVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqvs assertion failed");

`endif

// ----- rtl/fqvs_pkg.sv -----
// Package: widths, register codes, mode bits and shared types of the fractal step core.
package fqvs_pkg;

    localparam int FRAC_BITS   = 24;
    localparam int COORD_WIDTH = 32;
    localparam int DE_WIDTH    = 48;
    localparam int RAD_WIDTH   = 31;
    localparam int MODE_WIDTH  = 12;
    localparam int SCALE_WIDTH = 32;
    localparam int NUM_STAGES  = 7;

    localparam int APB_DATA_W  = 64;
    localparam int REG_IDX_W   = 3;
    localparam int ADDR_W      = REG_IDX_W + 3;

    // mode_flags bit positions
    localparam int MB_PREABS_X  = 0;
    localparam int MB_PREABS_Y  = 1;
    localparam int MB_PREABS_Z  = 2;
    localparam int MB_POSTABS_X = 3;
    localparam int MB_POSTABS_Y = 4;
    localparam int MB_POSTABS_Z = 5;
    localparam int MB_CUT       = 6;
    localparam int MB_SIGN_X    = 7;
    localparam int MB_FLIP      = 8;
    localparam int MB_ABS_YT    = 9;
    localparam int MB_ABS_ZT    = 10;
    localparam int MB_DE_ADJ    = 11;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODE,
        REG_SCALE_B,
        REG_SCALE_C,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_OFFSET_Z,
        REG_DE_SCALE,
        REG_DE_OFFSET
    } t_reg_idx;

    localparam logic [SCALE_WIDTH-1:0] SCALE_ONE = SCALE_WIDTH'(1) << FRAC_BITS;
    localparam logic [DE_WIDTH-1:0]    DE_ONE    = DE_WIDTH'(1) << FRAC_BITS;

    typedef struct packed {
        logic        [MODE_WIDTH-1:0]  mode;
        logic signed [SCALE_WIDTH-1:0] scale_b;
        logic signed [SCALE_WIDTH-1:0] scale_c;
        logic signed [SCALE_WIDTH-1:0] offset_x;
        logic signed [SCALE_WIDTH-1:0] offset_y;
        logic signed [SCALE_WIDTH-1:0] offset_z;
        logic signed [DE_WIDTH-1:0]    de_scale;
        logic signed [DE_WIDTH-1:0]    de_offset;
    } t_cfg;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

endpackage

// ----- rtl/fqvs_in_if.sv -----
// Input channel interface: point, distance derivative and radius word.
interface fqvs_in_if;
    import fqvs_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
    logic signed [DE_WIDTH-1:0]    in_de;
    logic        [RAD_WIDTH-1:0]   in_radius;

    modport source (output valid, in_x, in_y, in_z, in_de, in_radius, input ready);
    modport sink   (input valid, in_x, in_y, in_z, in_de, in_radius, output ready);
endinterface

// ----- rtl/fqvs_out_if.sv -----
// Output channel interface: new point, distance derivative and saturation flag.
interface fqvs_out_if;
    import fqvs_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic signed [DE_WIDTH-1:0]    out_de;
    logic                          saturated;

    modport source (output valid, out_x, out_y, out_z, out_de, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_de, saturated, output ready);
endinterface

// ----- rtl/fqvs_cfg_regs.sv -----
// APB register file holding the mode flags, scales and offsets.
module fqvs_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fqvs_pkg::ADDR_W-1:0]         paddr,
    input  logic [fqvs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fqvs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output fqvs_pkg::t_cfg                      o_cfg
);
    import fqvs_pkg::*;

    logic [MODE_WIDTH-1:0]  r_mode, n_mode;
    logic [SCALE_WIDTH-1:0] r_sb, n_sb;
    logic [SCALE_WIDTH-1:0] r_sc, n_sc;
    logic [SCALE_WIDTH-1:0] r_ox, n_ox;
    logic [SCALE_WIDTH-1:0] r_oy, n_oy;
    logic [SCALE_WIDTH-1:0] r_oz, n_oz;
    logic [DE_WIDTH-1:0]    r_ds, n_ds;
    logic [DE_WIDTH-1:0]    r_do, n_do;
    logic                   wr;
    t_reg_idx               idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    // byte address 8*i, low three bits ignored
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_comb begin
        n_mode = r_mode;
        n_sb   = r_sb;
        n_sc   = r_sc;
        n_ox   = r_ox;
        n_oy   = r_oy;
        n_oz   = r_oz;
        n_ds   = r_ds;
        n_do   = r_do;
        if (wr) begin
            unique case (idx)
                REG_MODE:      n_mode = pwdata[MODE_WIDTH-1:0];
                REG_SCALE_B:   n_sb   = pwdata[SCALE_WIDTH-1:0];
                REG_SCALE_C:   n_sc   = pwdata[SCALE_WIDTH-1:0];
                REG_OFFSET_X:  n_ox   = pwdata[SCALE_WIDTH-1:0];
                REG_OFFSET_Y:  n_oy   = pwdata[SCALE_WIDTH-1:0];
                REG_OFFSET_Z:  n_oz   = pwdata[SCALE_WIDTH-1:0];
                REG_DE_SCALE:  n_ds   = pwdata[DE_WIDTH-1:0];
                REG_DE_OFFSET: n_do   = pwdata[DE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_sb   <= SCALE_ONE;
            r_sc   <= SCALE_ONE;
            r_ox   <= '0;
            r_oy   <= '0;
            r_oz   <= '0;
            r_ds   <= DE_ONE;
            r_do   <= '0;
        end else begin
            r_mode <= n_mode;
            r_sb   <= n_sb;
            r_sc   <= n_sc;
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_oz   <= n_oz;
            r_ds   <= n_ds;
            r_do   <= n_do;
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:      prdata = APB_DATA_W'(r_mode);
            REG_SCALE_B:   prdata = APB_DATA_W'(r_sb);
            REG_SCALE_C:   prdata = APB_DATA_W'(r_sc);
            REG_OFFSET_X:  prdata = APB_DATA_W'(r_ox);
            REG_OFFSET_Y:  prdata = APB_DATA_W'(r_oy);
            REG_OFFSET_Z:  prdata = APB_DATA_W'(r_oz);
            REG_DE_SCALE:  prdata = APB_DATA_W'(r_ds);
            REG_DE_OFFSET: prdata = APB_DATA_W'(r_do);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.mode      = r_mode;
        o_cfg.scale_b   = r_sb;
        o_cfg.scale_c   = r_sc;
        o_cfg.offset_x  = r_ox;
        o_cfg.offset_y  = r_oy;
        o_cfg.offset_z  = r_oz;
        o_cfg.de_scale  = r_ds;
        o_cfg.de_offset = r_do;
    end

endmodule

// ----- rtl/fqvs_pipe_ctrl.sv -----
// Pipeline control: per-stage valid bits and load enables with ripple-back ready.
`include "fractal_quadratic_vector_step_core_assert.svh"

module fqvs_pipe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output fqvs_pkg::t_pipe_ctl o_ctl
);
    import fqvs_pkg::*;

    logic [NUM_STAGES-1:0] r_vld, n_vld;
    logic [NUM_STAGES:0]   rdy;
    logic                  in_acc;
    logic                  out_acc;

    // a stage may load when it is empty or its contents move on
    assign rdy[NUM_STAGES] = i_out_ready;
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end

    always_comb begin
        n_vld[0] = rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.load  = rdy[NUM_STAGES-1:0];
    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign in_acc      = i_in_valid && rdy[0];
    assign out_acc     = r_vld[NUM_STAGES-1] && i_out_ready;

    `FQVS_ASSERT_NEXT(a_fill, i_clk, i_rst_n, in_acc && !out_acc, $countones(r_vld) == $past($countones(r_vld)) + 1)
    `FQVS_ASSERT_NEXT(a_drain, i_clk, i_rst_n, !in_acc && out_acc, $countones(r_vld) + 1 == $past($countones(r_vld)))
    `FQVS_ASSERT_SAME(a_bubble_ready, i_clk, i_rst_n, !(&r_vld), rdy[0])

endmodule

// ----- rtl/fqvs_coord_path.sv -----
// Coordinate datapath: squares, sign choice, cross terms, post-abs, offset, clamp.
module fqvs_coord_path (
    input  logic                                   i_clk,
    input  fqvs_pkg::t_pipe_ctl                    i_ctl,
    input  fqvs_pkg::t_cfg                         i_cfg,
    input  logic signed [fqvs_pkg::COORD_WIDTH-1:0] i_x,
    input  logic signed [fqvs_pkg::COORD_WIDTH-1:0] i_y,
    input  logic signed [fqvs_pkg::COORD_WIDTH-1:0] i_z,
    output logic signed [fqvs_pkg::COORD_WIDTH-1:0] o_x,
    output logic signed [fqvs_pkg::COORD_WIDTH-1:0] o_y,
    output logic signed [fqvs_pkg::COORD_WIDTH-1:0] o_z,
    output logic                                   o_sat
);
    import fqvs_pkg::*;

    localparam int AW     = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int NXS_W  = SQ_W + 2;
    localparam int NX_W   = NXS_W - FRAC_BITS;
    localparam int TBP_W  = AW + SCALE_WIDTH;
    localparam int TB_W   = TBP_W - FRAC_BITS;
    localparam int TWOX_W = AW + 1;
    localparam int NYF_W  = ((TB_W > TWOX_W) ? TB_W : TWOX_W) + 1;
    localparam int NYF_LO = NYF_W / 2;
    localparam int NYF_HI = NYF_W - NYF_LO;
    localparam int PL_W   = AW + NYF_LO + 1;
    localparam int PH_W   = AW + NYF_HI;
    localparam int NYP_W  = AW + NYF_W;
    localparam int NY_W   = NYP_W - FRAC_BITS;
    localparam int CR_W   = (NX_W > NY_W) ? NX_W : NY_W;
    localparam int CO_W   = ((CR_W > SCALE_WIDTH) ? CR_W : SCALE_WIDTH) + 2;

    function automatic logic signed [AW-1:0] f_ext_abs(
        input logic signed [COORD_WIDTH-1:0] v,
        input logic                          take_abs
    );
        logic signed [AW-1:0] e;
        e = AW'(v);
        return (take_abs && v[COORD_WIDTH-1]) ? -e : e;
    endfunction

    function automatic logic signed [CO_W-1:0] f_post(
        input logic signed [CO_W-1:0] v,
        input logic                   take_abs
    );
        return (take_abs && v[CO_W-1]) ? -v : v;
    endfunction

    // clamp to the coordinate range; top bit of the result is the clamp flag
    function automatic logic [COORD_WIDTH:0] f_sat(input logic signed [CO_W-1:0] v);
        logic [CO_W-COORD_WIDTH:0] top;
        top = v[CO_W-1:COORD_WIDTH-1];
        if (top == '0 || top == '1) begin
            return {1'b0, v[COORD_WIDTH-1:0]};
        end else if (v[CO_W-1]) begin
            return {1'b1, 1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    logic [MODE_WIDTH-1:0] mode;
    assign mode = i_cfg.mode;

    // stage 0: abs selects, squares, scaled cross terms
    logic signed [AW-1:0]    n_ax, n_ay, n_az, n_ty, n_tz;
    logic signed [SQ_W-1:0]  r_sq_x, r_sq_y, r_sq_z;
    logic signed [TBP_W-1:0] r_pb, r_pc;
    logic signed [AW-1:0]    r_ax, r_ay, r_az;

    assign n_ax = f_ext_abs(i_x, mode[MB_PREABS_X]);
    assign n_ay = f_ext_abs(i_y, mode[MB_PREABS_Y]);
    assign n_az = f_ext_abs(i_z, mode[MB_PREABS_Z]);
    assign n_ty = f_ext_abs(i_y, mode[MB_ABS_YT]);
    assign n_tz = f_ext_abs(i_z, mode[MB_ABS_ZT]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_sq_x <= SQ_W'(i_x) * SQ_W'(i_x);
            r_sq_y <= SQ_W'(i_y) * SQ_W'(i_y);
            r_sq_z <= SQ_W'(i_z) * SQ_W'(i_z);
            r_pb   <= TBP_W'(n_tz) * TBP_W'($signed(i_cfg.scale_b));
            r_pc   <= TBP_W'(n_ty) * TBP_W'($signed(i_cfg.scale_c));
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_az   <= n_az;
        end
    end

    // stage 1: new x, sign, multiplier factors for new y and z
    logic signed [NXS_W-1:0] n_nxs;
    logic signed [TB_W-1:0]  n_tb, n_tc;
    logic signed [NYF_W-1:0] n_two_x;
    logic                    n_neg;
    logic signed [NX_W-1:0]  r_nx1;
    logic signed [NYF_W-1:0] r_nyf, r_nzf;
    logic signed [AW-1:0]    r_ay1, r_az1;

    always_comb begin
        n_nxs   = NXS_W'(r_sq_x) - NXS_W'(r_sq_y) - NXS_W'(r_sq_z);
        n_tb    = r_pb[TBP_W-1:FRAC_BITS];
        n_tc    = r_pc[TBP_W-1:FRAC_BITS];
        n_two_x = NYF_W'(r_ax) + NYF_W'(r_ax);
        // sign starts positive; cut rule, negative x and flip each toggle it
        n_neg   = (mode[MB_CUT] && (r_sq_z >= r_sq_y))
                ^ (!mode[MB_PREABS_Y] && mode[MB_SIGN_X] && r_ax[AW-1])
                ^ mode[MB_FLIP];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_nx1 <= n_nxs[NXS_W-1:FRAC_BITS];
            r_nyf <= n_neg ? (n_two_x + NYF_W'(n_tb)) : (n_two_x - NYF_W'(n_tb));
            r_nzf <= n_neg ? (n_two_x - NYF_W'(n_tc)) : (n_two_x + NYF_W'(n_tc));
            r_ay1 <= r_ay;
            r_az1 <= r_az;
        end
    end

    // stage 2: partial products of y*fy and z*fz
    logic signed [NYF_LO:0]   n_yf_lo, n_zf_lo;
    logic signed [NYF_HI-1:0] n_yf_hi, n_zf_hi;
    logic signed [PL_W-1:0]   r_py_lo, r_pz_lo;
    logic signed [PH_W-1:0]   r_py_hi, r_pz_hi;
    logic signed [NX_W-1:0]   r_nx2;

    assign n_yf_lo = $signed({1'b0, r_nyf[NYF_LO-1:0]});
    assign n_yf_hi = $signed(r_nyf[NYF_W-1:NYF_LO]);
    assign n_zf_lo = $signed({1'b0, r_nzf[NYF_LO-1:0]});
    assign n_zf_hi = $signed(r_nzf[NYF_W-1:NYF_LO]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_py_lo <= PL_W'(r_ay1) * PL_W'(n_yf_lo);
            r_py_hi <= PH_W'(r_ay1) * PH_W'(n_yf_hi);
            r_pz_lo <= PL_W'(r_az1) * PL_W'(n_zf_lo);
            r_pz_hi <= PH_W'(r_az1) * PH_W'(n_zf_hi);
            r_nx2   <= r_nx1;
        end
    end

    // stage 3: combine partials and rescale
    logic signed [NYP_W-1:0] n_py, n_pz;
    logic signed [NY_W-1:0]  r_ny3, r_nz3;
    logic signed [NX_W-1:0]  r_nx3;

    assign n_py = (NYP_W'(r_py_hi) <<< NYF_LO) + NYP_W'(r_py_lo);
    assign n_pz = (NYP_W'(r_pz_hi) <<< NYF_LO) + NYP_W'(r_pz_lo);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_ny3 <= n_py[NYP_W-1:FRAC_BITS];
            r_nz3 <= n_pz[NYP_W-1:FRAC_BITS];
            r_nx3 <= r_nx2;
        end
    end

    // stage 4: post-abs per axis
    logic signed [CO_W-1:0] r_cx4, r_cy4, r_cz4;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_cx4 <= f_post(CO_W'(r_nx3), mode[MB_POSTABS_X]);
            r_cy4 <= f_post(CO_W'(r_ny3), mode[MB_POSTABS_Y]);
            r_cz4 <= f_post(CO_W'(r_nz3), mode[MB_POSTABS_Z]);
        end
    end

    // stage 5: offsets
    logic signed [CO_W-1:0] r_cx5, r_cy5, r_cz5;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r_cx5 <= r_cx4 + CO_W'($signed(i_cfg.offset_x));
            r_cy5 <= r_cy4 + CO_W'($signed(i_cfg.offset_y));
            r_cz5 <= r_cz4 + CO_W'($signed(i_cfg.offset_z));
        end
    end

    // stage 6: clamp into the output register
    logic [COORD_WIDTH:0] n_sx, n_sy, n_sz;
    logic signed [COORD_WIDTH-1:0] r_ox, r_oy, r_oz;
    logic                          r_sat;

    assign n_sx = f_sat(r_cx5);
    assign n_sy = f_sat(r_cy5);
    assign n_sz = f_sat(r_cz5);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[6]) begin
            r_ox  <= n_sx[COORD_WIDTH-1:0];
            r_oy  <= n_sy[COORD_WIDTH-1:0];
            r_oz  <= n_sz[COORD_WIDTH-1:0];
            r_sat <= n_sx[COORD_WIDTH] | n_sy[COORD_WIDTH] | n_sz[COORD_WIDTH];
        end
    end

    assign o_x   = r_ox;
    assign o_y   = r_oy;
    assign o_z   = r_oz;
    assign o_sat = r_sat;

endmodule

// ----- rtl/fqvs_de_path.sv -----
// Distance-derivative datapath: 2*r*DE, optional scale and offset, clamp.
module fqvs_de_path (
    input  logic                                 i_clk,
    input  fqvs_pkg::t_pipe_ctl                  i_ctl,
    input  fqvs_pkg::t_cfg                       i_cfg,
    input  logic signed [fqvs_pkg::DE_WIDTH-1:0] i_de,
    input  logic        [fqvs_pkg::RAD_WIDTH-1:0] i_radius,
    output logic signed [fqvs_pkg::DE_WIDTH-1:0] o_de,
    output logic                                 o_sat
);
    import fqvs_pkg::*;

    localparam int DE_LO = DE_WIDTH / 2;
    localparam int DE_HI = DE_WIDTH - DE_LO;
    localparam int RS_W  = RAD_WIDTH + 1;
    localparam int PLO_W = DE_LO + 1 + RS_W;
    localparam int PHI_W = DE_HI + RS_W;
    localparam int DP_W  = DE_WIDTH + RAD_WIDTH + 1;
    localparam int D_W   = DP_W - FRAC_BITS;
    localparam int D_LO  = D_W / 2;
    localparam int D_HI  = D_W - D_LO;
    localparam int S_LO  = DE_WIDTH / 2;
    localparam int S_HI  = DE_WIDTH - S_LO;
    localparam int PHH_W = D_HI + S_HI;
    localparam int PHL_W = D_HI + S_LO + 1;
    localparam int PLH_W = D_LO + 1 + S_HI;
    localparam int PLL_W = D_LO + S_LO + 2;
    localparam int SH_W  = D_HI + DE_WIDTH;
    localparam int SL_W  = D_LO + 1 + DE_WIDTH;
    localparam int DDP_W = D_W + DE_WIDTH;
    localparam int DA_W  = DDP_W - FRAC_BITS;
    localparam int DF_W  = ((DA_W > DE_WIDTH) ? DA_W : DE_WIDTH) + 1;

    function automatic logic [DE_WIDTH:0] f_sat(input logic signed [DF_W-1:0] v);
        logic [DF_W-DE_WIDTH:0] top;
        top = v[DF_W-1:DE_WIDTH-1];
        if (top == '0 || top == '1) begin
            return {1'b0, v[DE_WIDTH-1:0]};
        end else if (v[DF_W-1]) begin
            return {1'b1, 1'b1, {(DE_WIDTH-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(DE_WIDTH-1){1'b1}}};
        end
    endfunction

    // stage 0: DE split in two halves times radius
    logic signed [RS_W-1:0]  n_rad;
    logic signed [DE_LO:0]   n_de_lo;
    logic signed [DE_HI-1:0] n_de_hi;
    logic signed [PLO_W-1:0] r_p_lo;
    logic signed [PHI_W-1:0] r_p_hi;

    assign n_rad   = $signed({1'b0, i_radius});
    assign n_de_lo = $signed({1'b0, i_de[DE_LO-1:0]});
    assign n_de_hi = $signed(i_de[DE_WIDTH-1:DE_LO]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_p_lo <= PLO_W'(n_de_lo) * PLO_W'(n_rad);
            r_p_hi <= PHI_W'(n_de_hi) * PHI_W'(n_rad);
        end
    end

    // stage 1: combine, double, rescale
    logic signed [DP_W-1:0] n_ps, n_dp;
    logic signed [D_W-1:0]  r_d1;

    assign n_ps = (DP_W'(r_p_hi) <<< DE_LO) + DP_W'(r_p_lo);
    assign n_dp = n_ps + n_ps;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_d1 <= n_dp[DP_W-1:FRAC_BITS];
        end
    end

    // stage 2: four partial products of d * de_scale
    logic signed [D_LO:0]   n_dl;
    logic signed [D_HI-1:0] n_dh;
    logic signed [S_LO:0]   n_sl;
    logic signed [S_HI-1:0] n_sh;
    logic signed [PHH_W-1:0] r_phh;
    logic signed [PHL_W-1:0] r_phl;
    logic signed [PLH_W-1:0] r_plh;
    logic signed [PLL_W-1:0] r_pll;
    logic signed [D_W-1:0]   r_d2;

    assign n_dl = $signed({1'b0, r_d1[D_LO-1:0]});
    assign n_dh = $signed(r_d1[D_W-1:D_LO]);
    assign n_sl = $signed({1'b0, i_cfg.de_scale[S_LO-1:0]});
    assign n_sh = $signed(i_cfg.de_scale[DE_WIDTH-1:S_LO]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_phh <= PHH_W'(n_dh) * PHH_W'(n_sh);
            r_phl <= PHL_W'(n_dh) * PHL_W'(n_sl);
            r_plh <= PLH_W'(n_dl) * PLH_W'(n_sh);
            r_pll <= PLL_W'(n_dl) * PLL_W'(n_sl);
            r_d2  <= r_d1;
        end
    end

    // stage 3: high-half and low-half sums
    logic signed [SH_W-1:0] r_s_hi;
    logic signed [SL_W-1:0] r_s_lo;
    logic signed [D_W-1:0]  r_d3;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_s_hi <= (SH_W'(r_phh) <<< S_LO) + SH_W'(r_phl);
            r_s_lo <= (SL_W'(r_plh) <<< S_LO) + SL_W'(r_pll);
            r_d3   <= r_d2;
        end
    end

    // stage 4: full product, rescale
    logic signed [DDP_W-1:0] n_prod;
    logic signed [DA_W-1:0]  r_da4;
    logic signed [D_W-1:0]   r_d4;

    assign n_prod = (DDP_W'(r_s_hi) <<< D_LO) + DDP_W'(r_s_lo);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_da4 <= n_prod[DDP_W-1:FRAC_BITS];
            r_d4  <= r_d3;
        end
    end

    // stage 5: offset when adjust is on, else plain 2*r*DE
    logic signed [DF_W-1:0] r_df5;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r_df5 <= i_cfg.mode[MB_DE_ADJ]
                   ? (DF_W'(r_da4) + DF_W'($signed(i_cfg.de_offset)))
                   : DF_W'(r_d4);
        end
    end

    // stage 6: clamp into the output register
    logic [DE_WIDTH:0]          n_s;
    logic signed [DE_WIDTH-1:0] r_de;
    logic                       r_sat;

    assign n_s = f_sat(r_df5);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[6]) begin
            r_de  <= n_s[DE_WIDTH-1:0];
            r_sat <= n_s[DE_WIDTH];
        end
    end

    assign o_de  = r_de;
    assign o_sat = r_sat;

endmodule

// ----- rtl/fractal_quadratic_vector_step_core.sv -----
// Top level of the quadratic 3D fractal step core.
//
//   channel  | dir | handshake        | words
//   i_in     | in  | valid / ready    | in_x, in_y, in_z, in_de, in_radius
//   o_out    | out | valid / ready    | out_x, out_y, out_z, out_de, saturated
//   APB      | in  | psel/penable     | 8 registers at byte address 8*i, 64-bit data
//
// Seven register stages; a word passes stages 0 to 6 in order before it leaves.
// One word per cycle sustained while the output side stays ready.
// Reset clears all stage valid bits and loads register defaults.
// A full stage holds while the stage after it cannot take its word; ready
// ripples back, so bubbles fill and input is taken while a result waits.
module fractal_quadratic_vector_step_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fqvs_in_if.sink                         i_in,
    fqvs_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fqvs_pkg::ADDR_W-1:0]     paddr,
    input  logic [fqvs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fqvs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import fqvs_pkg::*;

    t_cfg      cfg;
    t_pipe_ctl ctl;
    logic      sat_c;
    logic      sat_d;

    fqvs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fqvs_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_ctl       (ctl)
    );

    fqvs_coord_path u_coord (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_cfg (cfg),
        .i_x   (i_in.in_x),
        .i_y   (i_in.in_y),
        .i_z   (i_in.in_z),
        .o_x   (o_out.out_x),
        .o_y   (o_out.out_y),
        .o_z   (o_out.out_z),
        .o_sat (sat_c)
    );

    fqvs_de_path u_de (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_cfg    (cfg),
        .i_de     (i_in.in_de),
        .i_radius (i_in.in_radius),
        .o_de     (o_out.out_de),
        .o_sat    (sat_d)
    );

    assign o_out.saturated = sat_c | sat_d;

endmodule
